@@ rtl/hit_selection_sort_core_defines.svh @@
// Assertion macros used by the hit selection sort checker.
`ifndef HIT_SELECTION_SORT_CORE_DEFINES_SVH
`define HIT_SELECTION_SORT_CORE_DEFINES_SVH

// Check a consequence in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hit_selection_sort_core: next-cycle check failed");

// Check a consequence in the same cycle as the antecedent.
`define HSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hit_selection_sort_core: same-cycle check failed");

`endif

@@ rtl/hss_pkg.sv @@
// Shared constants, microcode field codes and interface structs of the hit sorter.
package hss_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ENTRY_W  = 2 * DATA_W;

  // Step numbers of the microprogram
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MARK     = 3'd1;
  localparam logic [2:0] ST_LOAD_MIN = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_SWAP_A   = 3'd4;
  localparam logic [2:0] ST_SWAP_B   = 3'd5;
  localparam logic [2:0] ST_OUT_REQ  = 3'd6;
  localparam logic [2:0] ST_OUT_LOAD = 3'd7;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_MARK = 2'd0,
    RD_IDX  = 2'd1,
    RD_OUT  = 2'd2
  } rd_sel_e;

  // Memory write source
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LOAD = 2'd1,
    WR_MIN  = 2'd2,
    WR_MARK = 2'd3
  } wr_sel_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_EOE       = 3'd2,
    C_MARK_DONE = 3'd3,
    C_SCAN_DONE = 3'd4,
    C_OUT_FREE  = 3'd5,
    C_OUT_LAST  = 3'd6
  } cond_e;

  // Step counter action when no jump is taken
  typedef enum logic [1:0] {
    F_NEXT = 2'd0,
    F_HOLD = 2'd1,
    F_BACK = 2'd2
  } fall_e;

  // Datapath control, one set per step
  typedef struct packed {
    logic    in_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    clr_ptrs;
    logic    set_idx;
    logic    ld_min;
    logic    scan_cmp;
    logic    inc_idx;
    logic    inc_mark;
    logic    out_load;
  } ctrl_t;

  // Full microcode word
  typedef struct packed {
    ctrl_t      ctrl;
    cond_e      cond;
    logic [2:0] target;
    fall_e      fall;
  } uword_t;

  // Datapath status for conditional jumps
  typedef struct packed {
    logic eoe_acc;
    logic mark_done;
    logic scan_done;
    logic out_free;
    logic out_last;
  } stat_t;

endpackage

@@ rtl/hss_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module hss_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hss_pkg::stat_t stat_i,
  output hss_pkg::ctrl_t ctrl_o
);

  logic [2:0]        step_q, step_d;
  hss_pkg::uword_t   uw;
  logic              taken;

  // Look up the control word of one step
  function automatic hss_pkg::uword_t ucode(logic [2:0] s);
    hss_pkg::uword_t w;
    w = '0;
    w.ctrl.rd_sel = hss_pkg::RD_MARK;
    w.ctrl.wr_sel = hss_pkg::WR_NONE;
    w.cond        = hss_pkg::C_NEVER;
    w.target      = hss_pkg::ST_IDLE;
    w.fall        = hss_pkg::F_NEXT;
    unique case (s)
      hss_pkg::ST_IDLE: begin
        w.ctrl.in_en    = 1'b1;
        w.ctrl.wr_sel   = hss_pkg::WR_LOAD;
        w.ctrl.clr_ptrs = 1'b1;
        w.cond          = hss_pkg::C_EOE;
        w.target        = hss_pkg::ST_MARK;
        w.fall          = hss_pkg::F_HOLD;
      end
      hss_pkg::ST_MARK: begin
        w.ctrl.rd_sel  = hss_pkg::RD_MARK;
        w.ctrl.set_idx = 1'b1;
        w.cond         = hss_pkg::C_MARK_DONE;
        w.target       = hss_pkg::ST_OUT_REQ;
      end
      hss_pkg::ST_LOAD_MIN: begin
        w.ctrl.rd_sel  = hss_pkg::RD_IDX;
        w.ctrl.ld_min  = 1'b1;
        w.ctrl.inc_idx = 1'b1;
      end
      hss_pkg::ST_SCAN: begin
        w.ctrl.rd_sel   = hss_pkg::RD_IDX;
        w.ctrl.scan_cmp = 1'b1;
        w.ctrl.inc_idx  = 1'b1;
        w.cond          = hss_pkg::C_SCAN_DONE;
        w.target        = hss_pkg::ST_SWAP_A;
        w.fall          = hss_pkg::F_HOLD;
      end
      hss_pkg::ST_SWAP_A: begin
        w.ctrl.wr_sel = hss_pkg::WR_MIN;
      end
      hss_pkg::ST_SWAP_B: begin
        w.ctrl.wr_sel   = hss_pkg::WR_MARK;
        w.ctrl.inc_mark = 1'b1;
        w.cond          = hss_pkg::C_ALWAYS;
        w.target        = hss_pkg::ST_MARK;
      end
      hss_pkg::ST_OUT_REQ: begin
        w.ctrl.rd_sel = hss_pkg::RD_OUT;
        w.cond        = hss_pkg::C_OUT_FREE;
        w.target      = hss_pkg::ST_OUT_LOAD;
        w.fall        = hss_pkg::F_HOLD;
      end
      hss_pkg::ST_OUT_LOAD: begin
        w.ctrl.out_load = 1'b1;
        w.cond          = hss_pkg::C_OUT_LAST;
        w.target        = hss_pkg::ST_IDLE;
        w.fall          = hss_pkg::F_BACK;
      end
      default: begin
        w.fall = hss_pkg::F_HOLD;
      end
    endcase
    return w;
  endfunction

  assign uw     = ucode(step_q);
  assign ctrl_o = uw.ctrl;

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      hss_pkg::C_NEVER:     taken = 1'b0;
      hss_pkg::C_ALWAYS:    taken = 1'b1;
      hss_pkg::C_EOE:       taken = stat_i.eoe_acc;
      hss_pkg::C_MARK_DONE: taken = stat_i.mark_done;
      hss_pkg::C_SCAN_DONE: taken = stat_i.scan_done;
      hss_pkg::C_OUT_FREE:  taken = stat_i.out_free;
      hss_pkg::C_OUT_LAST:  taken = stat_i.out_last;
      default:              taken = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    if (taken) begin
      step_d = uw.target;
    end else begin
      case (uw.fall)
        hss_pkg::F_NEXT: step_d = step_q + 3'd1;
        hss_pkg::F_BACK: step_d = step_q - 3'd1;
        default:         step_d = step_q;
      endcase
    end
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hss_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/hss_dp.sv @@
// Datapath: hit memory, pointers, running minimum and output register.
module hss_dp #(
  parameter int unsigned CAPACITY = hss_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hss_pkg::ctrl_t                    ctrl_i,
  output hss_pkg::stat_t                    stat_o,
  input  logic                              in_valid_i,
  input  logic signed [hss_pkg::DATA_W-1:0] hit_time_i,
  input  logic signed [hss_pkg::DATA_W-1:0] hit_height_i,
  input  logic                              end_of_event_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hss_pkg::DATA_W-1:0] sorted_time_o,
  output logic signed [hss_pkg::DATA_W-1:0] sorted_height_o,
  output logic                              final_hit_o,
  output logic                              overflow_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = hss_pkg::ENTRY_W;
  localparam int unsigned DW = hss_pkg::DATA_W;

  logic [EW-1:0] mem [CAPACITY];

  logic [CW-1:0] count_q, mark_q, idx_q, out_idx_q;
  logic          dropped_q, out_valid_q;
  logic [AW-1:0] low_q, rd_addr_q;
  logic [EW-1:0] min_q, mark_ent_q, rd_data_q;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic          full, in_acc, out_last, scan_done, is_less;

  assign full      = (count_q == CW'(CAPACITY));
  assign in_acc    = in_valid_i & ctrl_i.in_en;
  assign out_last  = (CW'(out_idx_q + CW'(1)) == count_q);
  assign scan_done = (idx_q >= count_q);
  assign is_less   = $signed(rd_data_q[EW-1:DW]) < $signed(min_q[EW-1:DW]);

  // Status for the sequencer
  assign stat_o.eoe_acc   = in_acc & end_of_event_i;
  assign stat_o.mark_done = (CW'(mark_q + CW'(1)) >= count_q);
  assign stat_o.scan_done = scan_done;
  assign stat_o.out_free  = ~out_valid_q | ~out_stall_i;
  assign stat_o.out_last  = out_last;

  // Select the read address
  always_comb begin
    unique case (ctrl_i.rd_sel)
      hss_pkg::RD_MARK: rd_addr = mark_q[AW-1:0];
      hss_pkg::RD_IDX:  rd_addr = idx_q[AW-1:0];
      hss_pkg::RD_OUT:  rd_addr = out_idx_q[AW-1:0];
      default:          rd_addr = mark_q[AW-1:0];
    endcase
  end

  // Select the write port source
  always_comb begin
    unique case (ctrl_i.wr_sel)
      hss_pkg::WR_LOAD: begin
        wr_en   = in_acc & ~full;
        wr_addr = count_q[AW-1:0];
        wr_data = {hit_time_i, hit_height_i};
      end
      hss_pkg::WR_MIN: begin
        wr_en   = 1'b1;
        wr_addr = mark_q[AW-1:0];
        wr_data = min_q;
      end
      hss_pkg::WR_MARK: begin
        wr_en   = 1'b1;
        wr_addr = low_q;
        wr_data = mark_ent_q;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = low_q;
        wr_data = mark_ent_q;
      end
    endcase
  end

  // Hit memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Track the running minimum of the scan
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_min) begin
      min_q      <= rd_data_q;
      mark_ent_q <= rd_data_q;
      low_q      <= rd_addr_q;
    end else if (ctrl_i.scan_cmp && is_less) begin
      min_q <= rd_data_q;
      low_q <= rd_addr_q;
    end
  end

  // Fill count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (ctrl_i.out_load && out_last) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (in_acc) begin
      if (full) begin
        dropped_q <= 1'b1;
      end else begin
        count_q <= CW'(count_q + CW'(1));
      end
    end
  end

  // Sort and output pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q    <= '0;
      idx_q     <= '0;
      out_idx_q <= '0;
    end else begin
      if (ctrl_i.clr_ptrs) begin
        mark_q    <= '0;
        out_idx_q <= '0;
      end else begin
        if (ctrl_i.inc_mark) begin
          mark_q <= CW'(mark_q + CW'(1));
        end
        if (ctrl_i.out_load) begin
          out_idx_q <= CW'(out_idx_q + CW'(1));
        end
      end
      if (ctrl_i.set_idx) begin
        idx_q <= CW'(mark_q + CW'(1));
      end else if (ctrl_i.inc_idx && !scan_done) begin
        idx_q <= CW'(idx_q + CW'(1));
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      sorted_time_o   <= rd_data_q[EW-1:DW];
      sorted_height_o <= rd_data_q[DW-1:0];
      final_hit_o     <= out_last;
      overflow_o      <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/hit_selection_sort_core.sv @@
// Top level of the hit selection sorter: microcode sequencer plus datapath.
//
//   channel   direction  handshake             payload
//   input     in         in_valid_i/in_stall_o  hit_time_i, hit_height_i, end_of_event_i
//   output    out        out_valid_o/out_stall_i sorted_time_o, sorted_height_o,
//                                                final_hit_o, overflow_o
//
// A hit without end of event is accepted and the input stays open for the next hit. An
// event is then sorted with one compare per cycle on the single memory read port, plus
// mark, minimum load and two swap writes for every position but the last, and one closing
// mark check; results are emitted with an output request step and a load step per hit.
// Reset clears the fill count, the pointers and the step counter; the memory is not cleared.
// Input is stalled from the end-of-event transaction until the final result is loaded.
// An output stall on a valid result holds the result register and holds the sequencer in its output request step.
module hit_selection_sort_core #(
  parameter int unsigned CAPACITY = hss_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [hss_pkg::DATA_W-1:0] hit_time_i,
  input  logic signed [hss_pkg::DATA_W-1:0] hit_height_i,
  input  logic                              end_of_event_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hss_pkg::DATA_W-1:0] sorted_time_o,
  output logic signed [hss_pkg::DATA_W-1:0] sorted_height_o,
  output logic                              final_hit_o,
  output logic                              overflow_o
);

  hss_pkg::ctrl_t ctrl;
  hss_pkg::stat_t stat;

  // Stall input outside the load step
  assign in_stall_o = ~ctrl.in_en;

  hss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  hss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .in_valid_i      (in_valid_i),
    .hit_time_i      (hit_time_i),
    .hit_height_i    (hit_height_i),
    .end_of_event_i  (end_of_event_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sorted_time_o   (sorted_time_o),
    .sorted_height_o (sorted_height_o),
    .final_hit_o     (final_hit_o),
    .overflow_o      (overflow_o)
  );

endmodule

@@ rtl/hss_checker.sv @@
// Port-level checker for the hit selection sorter and its bind.
`include "hit_selection_sort_core_defines.svh"

module hss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              end_of_event_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [hss_pkg::DATA_W-1:0] sorted_time_o,
  input logic signed [hss_pkg::DATA_W-1:0] sorted_height_o,
  input logic                              final_hit_o,
  input logic                              overflow_o
);

  // Hold a stalled result
  `HSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sorted_time_o) && $stable(sorted_height_o) && $stable(final_hit_o) && $stable(overflow_o))

  // Stall input once an event is closed
  `HSS_ASSERT_NEXT(a_eoe_stalls, in_valid_i && !in_stall_o && end_of_event_i, in_stall_o)

  // Keep input stalled while results of the event remain
  `HSS_ASSERT_NOW(a_more_pending, out_valid_o && !final_hit_o, in_stall_o)

  // Drop output valid after the final transaction
  `HSS_ASSERT_NEXT(a_final_drop, out_valid_o && !out_stall_i && final_hit_o, !out_valid_o)

endmodule

bind hit_selection_sort_core hss_checker u_hss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .end_of_event_i  (end_of_event_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sorted_time_o   (sorted_time_o),
  .sorted_height_o (sorted_height_o),
  .final_hit_o     (final_hit_o),
  .overflow_o      (overflow_o)
);
